// ----- rtl/ied_pkg.sv -----
// Shared types and constants of the eight-channel input debouncer.
package ied_pkg;

    // Largest number of channels one port sample can feed
    localparam int unsigned MAX_CHANNELS = 8;

    // Port sample, count, relay and channel number widths
    localparam int unsigned SAMPLE_W = 8;
    localparam int unsigned COUNT_W  = 8;
    localparam int unsigned RELAY_W  = 4;
    localparam int unsigned CHAN_W   = 4;

    // APB port shape
    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned APB_DATA_W = 32;

    // Register indexes (word address = byte address / 4)
    localparam logic [1:0] REG_TRIP_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_RELAY_BITS     = 2'd1;
    localparam logic [1:0] REG_CUSTOM_MAPPING = 2'd2;

    // Reset values of the registers
    localparam logic [COUNT_W-1:0] THRESHOLD_RESET = 8'd3;
    localparam logic [RELAY_W-1:0] RELAY_RESET     = 4'd0;

    // Saturation point of the run counter
    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

    // Configuration seen by the datapath
    typedef struct packed {
        logic [COUNT_W-1:0] trip_threshold;
        logic [RELAY_W-1:0] relay_bits;
        logic               custom_mapping;
    } cfg_t;

    // Change found by one channel lane on the current sample
    typedef struct packed {
        logic hit;
        logic level;
    } lane_evt_t;

endpackage

// ----- rtl/ied_if.sv -----
// Valid/ready channel interfaces for port samples and change events.
interface ied_sample_if;
    logic                             valid;
    logic                             ready;
    logic [ied_pkg::SAMPLE_W-1:0]     port_sample;
    logic                             report_events;

    modport source (output valid, output port_sample, output report_events, input ready);
    modport sink   (input valid, input port_sample, input report_events, output ready);
endinterface

interface ied_event_if;
    logic                         valid;
    logic                         ready;
    logic [ied_pkg::CHAN_W-1:0]   channel_number;
    logic                         new_level;
    logic                         last_event;

    modport source (output valid, output channel_number, output new_level,
                    output last_event, input ready);
    modport sink   (input valid, input channel_number, input new_level,
                    input last_event, output ready);
endinterface

// ----- rtl/ied_regs.sv -----
// APB configuration registers of the debouncer.
module ied_regs
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ied_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [ied_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ied_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output ied_pkg::cfg_t                     cfg
);

    ied_pkg::cfg_t cfg_reg;
    ied_pkg::cfg_t cfg_next;
    logic          wr_en;
    logic [1:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    // Decode the write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                ied_pkg::REG_TRIP_THRESHOLD:
                    cfg_next.trip_threshold = pwdata[ied_pkg::COUNT_W-1:0];
                ied_pkg::REG_RELAY_BITS:
                    cfg_next.relay_bits = pwdata[ied_pkg::RELAY_W-1:0];
                ied_pkg::REG_CUSTOM_MAPPING:
                    cfg_next.custom_mapping = pwdata[0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trip_threshold <= ied_pkg::THRESHOLD_RESET;
            cfg_reg.relay_bits     <= ied_pkg::RELAY_RESET;
            cfg_reg.custom_mapping <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back the addressed register
    always_comb
    begin
        unique case (reg_idx)
            ied_pkg::REG_TRIP_THRESHOLD:
                prdata = ied_pkg::APB_DATA_W'(cfg_reg.trip_threshold);
            ied_pkg::REG_RELAY_BITS:
                prdata = ied_pkg::APB_DATA_W'(cfg_reg.relay_bits);
            ied_pkg::REG_CUSTOM_MAPPING:
                prdata = ied_pkg::APB_DATA_W'(cfg_reg.custom_mapping);
            default:
                prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/ied_lane.sv -----
// One debounce lane: saturating run counter and tripped flag of a channel.
module ied_lane
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           step,
    input  logic                           active,
    input  logic [ied_pkg::COUNT_W-1:0]    trip_threshold,
    output ied_pkg::lane_evt_t             evt
);

    logic [ied_pkg::COUNT_W-1:0] count_reg;
    logic [ied_pkg::COUNT_W-1:0] count_next;
    logic                        tripped_reg;
    logic                        tripped_next;
    logic [ied_pkg::COUNT_W-1:0] count_inc;

    // Saturate the run count
    assign count_inc = (count_reg == ied_pkg::COUNT_MAX) ? count_reg
                                                         : count_reg + 1'b1;

    // Trip on reaching the threshold, release at once on an idle sample
    always_comb
    begin
        evt.hit   = 1'b0;
        evt.level = active;
        if (active)
        begin
            count_next   = count_inc;
            tripped_next = tripped_reg;
            if (count_inc >= trip_threshold && !tripped_reg)
            begin
                tripped_next = 1'b1;
                evt.hit      = 1'b1;
            end
        end
        else
        begin
            count_next   = '0;
            tripped_next = 1'b0;
            evt.hit      = tripped_reg;
        end
    end

    // Advance on each accepted sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            tripped_reg <= 1'b0;
        end
        else if (step)
        begin
            count_reg   <= count_next;
            tripped_reg <= tripped_next;
        end
    end

endmodule

// ----- rtl/ied_merge.sv -----
// Event merge: queue the lane changes of one sample and drain one per beat.
module ied_merge #(
    parameter int unsigned CHANNELS = ied_pkg::MAX_CHANNELS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  logic [CHANNELS-1:0]   hit_mask,
    input  logic [CHANNELS-1:0]   levels,
    output logic                  ready,
    ied_event_if.source           event_chan
);

    logic [CHANNELS-1:0]         pend_reg;
    logic [CHANNELS-1:0]         pend_next;
    logic [CHANNELS-1:0]         level_reg;
    logic [CHANNELS-1:0]         level_next;
    logic [CHANNELS-1:0]         pend_rest;
    logic [CHANNELS-1:0]         pend_after;
    logic                        move;
    logic [ied_pkg::CHAN_W-1:0]  sel_chan;
    logic                        sel_level;

    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [ied_pkg::CHAN_W-1:0]  out_chan_reg;
    logic [ied_pkg::CHAN_W-1:0]  out_chan_next;
    logic                        out_level_reg;
    logic                        out_level_next;
    logic                        out_last_reg;
    logic                        out_last_next;

    // Pick the lowest pending channel
    always_comb
    begin
        sel_chan  = '0;
        sel_level = 1'b0;
        for (int c = CHANNELS - 1; c >= 0; c--)
        begin
            if (pend_reg[c])
            begin
                sel_chan  = ied_pkg::CHAN_W'(c + 1);
                sel_level = level_reg[c];
            end
        end
    end

    // Drop the lowest pending bit once it moves to the output register
    assign pend_rest  = pend_reg & (pend_reg - CHANNELS'(1));
    assign move       = (|pend_reg) && (!out_valid_reg || event_chan.ready);
    assign pend_after = move ? pend_rest : pend_reg;
    assign ready      = (pend_after == '0);

    always_comb
    begin
        pend_next  = load ? hit_mask : pend_after;
        level_next = load ? levels : level_reg;
    end

    // Load or retire the output beat
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_chan_next  = out_chan_reg;
        out_level_next = out_level_reg;
        out_last_next  = out_last_reg;
        if (move)
        begin
            out_valid_next = 1'b1;
            out_chan_next  = sel_chan;
            out_level_next = sel_level;
            out_last_next  = (pend_rest == '0);
        end
        else if (event_chan.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        level_reg     <= level_next;
        out_chan_reg  <= out_chan_next;
        out_level_reg <= out_level_next;
        out_last_reg  <= out_last_next;
    end

    assign event_chan.valid          = out_valid_reg;
    assign event_chan.channel_number = out_chan_reg;
    assign event_chan.new_level      = out_level_reg;
    assign event_chan.last_event     = out_last_reg;

endmodule

// ----- rtl/eight_channel_input_debouncer_top.sv -----
// Top level of the eight-channel input debouncer.
// Each beat on sample_chan is one raw, active-low port byte; it is inverted,
// shifted right by relay_bits unless custom_mapping is set, and bit c feeds
// channel lane c, which all update in the cycle the beat is accepted. Trips
// and releases of a sample are queued in the merge stage and leave on
// event_chan one per cycle while it is ready, lowest channel first, through
// an output register. A sample with no event is taken every cycle while no
// earlier event is pending; one with events holds the input until its last
// event enters the output register, and the next sample is taken while that
// event waits to be read. Registers sit at byte addresses 0, 4 and 8 of the
// APB port: trip_threshold, relay_bits, custom_mapping.
module eight_channel_input_debouncer_top #(
    parameter int unsigned CHANNELS = ied_pkg::MAX_CHANNELS
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    ied_sample_if.sink                        sample_chan,
    ied_event_if.source                       event_chan,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ied_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [ied_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ied_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    ied_pkg::cfg_t                 cfg;
    logic                          accept;
    logic                          merge_ready;
    logic [ied_pkg::SAMPLE_W-1:0]  cond_sample;
    logic [CHANNELS-1:0]           hit_mask;
    logic [CHANNELS-1:0]           levels;
    ied_pkg::lane_evt_t            lane_evt [CHANNELS];

    ied_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign sample_chan.ready = merge_ready;
    assign accept            = sample_chan.valid && merge_ready;

    // Invert, and drop the relay bits unless custom_mapping is set
    always_comb
    begin
        cond_sample = ~sample_chan.port_sample;
        if (!cfg.custom_mapping)
        begin
            if (cfg.relay_bits >= ied_pkg::RELAY_W'(ied_pkg::SAMPLE_W))
                cond_sample = '0;
            else
                cond_sample = cond_sample >> cfg.relay_bits;
        end
    end

    // One lane per channel
    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_lane
        ied_lane u_lane (
            .clk            (clk),
            .rst_n          (rst_n),
            .step           (accept),
            .active         (cond_sample[c]),
            .trip_threshold (cfg.trip_threshold),
            .evt            (lane_evt[c])
        );

        assign hit_mask[c] = lane_evt[c].hit && sample_chan.report_events;
        assign levels[c]   = lane_evt[c].level;
    end

    ied_merge #(
        .CHANNELS (CHANNELS)
    ) u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .hit_mask   (hit_mask),
        .levels     (levels),
        .ready      (merge_ready),
        .event_chan (event_chan)
    );

endmodule
